/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ACT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("act assertion failed");

// next-cycle implication
`define ACT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("act assertion failed");

`endif

/* hw/rtl/act_pkg.sv */
package act_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int NORM_W       = 20;
  localparam int GAIN_W       = 21;
  localparam int REG_W        = 63;
  localparam int NUM_REGS     = 4;
  localparam int REG_IDX_W    = 2;
  localparam int PROD_W       = 37;
  localparam int SUM_W        = 40;
  localparam int RND_SHIFT    = 13;
  localparam int SQ_W         = 39;
  localparam int SSQ_W        = 40;
  localparam int ROOT_W       = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int ZFRAC        = 24;
  localparam int XY_W         = 48;
  localparam int Z_W          = 36;
  localparam int ANGLE_W      = 16;

  localparam int CAL_LAT  = 3;
  localparam int LANE_LAT = 1 + ROOT_W + CORDIC_STEPS + 1;
  localparam int PIPE_LAT = CAL_LAT + LANE_LAT;

  localparam logic signed [SUM_W-1:0] NORM_MAX = SUM_W'(524287);
  localparam logic signed [SUM_W-1:0] NORM_MIN = -SUM_W'(524288);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_X = 2'd0,
    REG_GAIN_Y = 2'd1,
    REG_GAIN_Z = 2'd2,
    REG_OFFSET = 2'd3
  } cfg_reg_t;

  typedef logic signed [NORM_W-1:0] norm_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [ANGLE_W-1:0]       pitch_deg;
    logic [ANGLE_W-1:0]       roll_deg;
  } out_item_t;

  typedef struct packed {
    norm_t x;
    norm_t y;
    norm_t z;
  } norm_vec_t;

  typedef struct packed {
    logic [REG_W-1:0] gain_x;
    logic [REG_W-1:0] gain_y;
    logic [REG_W-1:0] gain_z;
    logic [REG_W-1:0] offset;
  } cal_cfg_t;

  typedef struct packed {
    logic zden;
    logic npos;
    logic nneg;
  } lane_flag_t;

  // atan(2^-k) in degrees, 24 fractional bits
  function automatic logic signed [Z_W-1:0] atan_deg_q24(input int unsigned k);
    logic signed [Z_W-1:0] v;
    case (k)
      0: v = Z_W'(754974720);
      1: v = Z_W'(445687602);
      2: v = Z_W'(235489088);
      3: v = Z_W'(119537938);
      4: v = Z_W'(60000934);
      5: v = Z_W'(30029717);
      6: v = Z_W'(15018523);
      7: v = Z_W'(7509720);
      8: v = Z_W'(3754917);
      9: v = Z_W'(1877466);
      10: v = Z_W'(938734);
      11: v = Z_W'(469367);
      12: v = Z_W'(234684);
      13: v = Z_W'(117342);
      14: v = Z_W'(58671);
      15: v = Z_W'(29335);
      16: v = Z_W'(14668);
      17: v = Z_W'(7334);
      18: v = Z_W'(3667);
      19: v = Z_W'(1833);
      20: v = Z_W'(917);
      21: v = Z_W'(458);
      22: v = Z_W'(229);
      23: v = Z_W'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/act_calib.sv */
module act_calib import act_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  cal_cfg_t  cfg,
  input  in_item_t  sample,
  output norm_vec_t norm,
  output logic [SQ_W-1:0] sq_x,
  output logic [SQ_W-1:0] sq_y,
  output logic [SQ_W-1:0] sq_z
);

  logic signed [SAMPLE_BITS-1:0] acc [3];
  logic [REG_W-1:0] rows [3];
  logic signed [GAIN_W-1:0] gain [3][3];
  logic signed [GAIN_W-1:0] offs [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [SUM_W-1:0] sum [3];
  logic signed [SUM_W-1:0] rnd [3];
  norm_t sat [3];
  norm_t nv [3];
  norm_t nv3 [3];
  logic signed [2*NORM_W-1:0] sq [3];

  always_comb begin
    acc[0] = sample.accel_x;
    acc[1] = sample.accel_y;
    acc[2] = sample.accel_z;
    rows[0] = cfg.gain_x;
    rows[1] = cfg.gain_y;
    rows[2] = cfg.gain_z;
    for (int i = 0; i < 3; i++) begin
      offs[i] = cfg.offset[i*GAIN_W +: GAIN_W];
      for (int j = 0; j < 3; j++) begin
        gain[i][j] = rows[i][j*GAIN_W +: GAIN_W];
      end
    end
  end

  // products: prod[j][i] = sample i times gain for output j
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod[j][i] <= PROD_W'(acc[i]) * PROD_W'(gain[i][j]);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = (SUM_W'(offs[j]) <<< RND_SHIFT) + SUM_W'(prod[j][0])
             + SUM_W'(prod[j][1]) + SUM_W'(prod[j][2])
             + (SUM_W'(1) <<< (RND_SHIFT - 1));
      rnd[j] = sum[j] >>> RND_SHIFT;
      if (rnd[j] > NORM_MAX) begin
        sat[j] = NORM_MAX[NORM_W-1:0];
      end else if (rnd[j] < NORM_MIN) begin
        sat[j] = NORM_MIN[NORM_W-1:0];
      end else begin
        sat[j] = rnd[j][NORM_W-1:0];
      end
      sq[j] = nv[j] * nv[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        nv[j] <= sat[j];
        nv3[j] <= nv[j];
      end
      sq_x <= sq[0][SQ_W-1:0];
      sq_y <= sq[1][SQ_W-1:0];
      sq_z <= sq[2][SQ_W-1:0];
    end
  end

  assign norm = '{x: nv3[0], y: nv3[1], z: nv3[2]};

endmodule

/* hw/rtl/act_lane.sv */
module act_lane import act_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               en,
  input  norm_t              num,
  input  logic [SQ_W-1:0]    sq_a,
  input  logic [SQ_W-1:0]    sq_b,
  output logic [ANGLE_W-1:0] angle
);

  localparam int TW    = SSQ_W + 2;
  localparam int SHIFT = ZFRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] TOP      = Z_W'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] MID      = Z_W'(90) <<< ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] NINETY_Z = Z_W'(90) <<< ZFRAC;
  localparam logic signed [Z_W-1:0] HALF     = Z_W'(1) <<< (SHIFT - 1);

  logic [SSQ_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  norm_t             snum [ROOT_W+1];

  logic signed [XY_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz [CORDIC_STEPS+1];
  lane_flag_t             flg [CORDIC_STEPS+1];

  logic signed [Z_W-1:0] zs;
  logic signed [Z_W-1:0] rs;
  logic signed [Z_W-1:0] res;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= SSQ_W'(sq_a) + SSQ_W'(sq_b);
      root[0] <= '0;
      snum[0] <= num;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - k;
    logic [TW-1:0] trial;
    assign trial = (TW'(root[k]) << (B + 1)) + (TW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        snum[k+1] <= snum[k];
        if (TW'(rem[k]) >= trial) begin
          rem[k+1]  <= rem[k] - trial[SSQ_W-1:0];
          root[k+1] <= root[k] | (ROOT_W'(1) << B);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
      end
    end
  end

  assign cx[0]  = XY_W'({1'b0, root[ROOT_W]}) <<< ZFRAC;
  assign cy[0]  = XY_W'(snum[ROOT_W]) <<< ZFRAC;
  assign cz[0]  = '0;
  assign flg[0] = '{zden: (root[ROOT_W] == '0),
                    npos: (snum[ROOT_W] > 0),
                    nneg: (snum[ROOT_W] < 0)};

  // vectoring cordic, one rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    assign xs = cx[k] >>> k;
    assign ys = cy[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        flg[k+1] <= flg[k];
        if (cy[k] > 0) begin
          cx[k+1] <= cx[k] + ys;
          cy[k+1] <= cy[k] - xs;
          cz[k+1] <= cz[k] + atan_deg_q24(k);
        end else begin
          cx[k+1] <= cx[k] - ys;
          cy[k+1] <= cy[k] + xs;
          cz[k+1] <= cz[k] - atan_deg_q24(k);
        end
      end
    end
  end

  always_comb begin
    zs = cz[CORDIC_STEPS] + NINETY_Z + HALF;
    rs = zs >>> SHIFT;
    if (flg[CORDIC_STEPS].zden) begin
      if (flg[CORDIC_STEPS].npos) begin
        res = TOP;
      end else if (flg[CORDIC_STEPS].nneg) begin
        res = '0;
      end else begin
        res = MID;
      end
    end else if (rs < 0) begin
      res = '0;
    end else if (rs > TOP) begin
      res = TOP;
    end else begin
      res = rs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= res[ANGLE_W-1:0];
    end
  end

endmodule

/* hw/rtl/act_merge.sv */
module act_merge import act_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               last_valid,
  input  norm_vec_t          norm,
  input  logic [ANGLE_W-1:0] pitch,
  input  logic [ANGLE_W-1:0] roll,
  input  logic               out_ready,
  output logic               out_valid,
  output out_item_t          out_item,
  output logic               adv
);

  // pipeline moves unless a finished item would overwrite a stalled one
  assign adv = !(out_valid && !out_ready && last_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && last_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_valid) begin
      out_item <= '{norm_x: norm.x, norm_y: norm.y, norm_z: norm.z,
                    pitch_deg: pitch, roll_deg: roll};
    end
  end

endmodule

/* hw/rtl/accel_calibrate_tilt_angles_unit.sv */
// accelerometer calibration and tilt angles
// in_item carries one milli-g sample on a valid/ready channel; out_item carries
// the calibrated Q16 vector and pitch and roll, plus 90 degrees, with
// ANGLE_FRAC_BITS fractional bits, on a valid/ready channel.
// cfg_we writes cfg_data into register cfg_index at once: gain rows for x, y, z
// and the offset row, each three signed 21-bit fields.
// throughput: one item per cycle while in_ready is high. the item passes 50
// register stages, the first loaded at the accepting edge: 3 calibration
// stages, one sum-of-squares stage, 20 square-root stages, 24 cordic stages,
// one rounding stage and the output register.
// pitch and roll run in two identical lanes.
// reset clears the configuration registers to zero and empties the pipeline.
// when the receiver stalls, the output register holds its item and the
// pipeline keeps accepting items until one reaches its last stage; then
// in_ready drops until the output item is taken.
`include "assert_macros.svh"

module accel_calibrate_tilt_angles_unit import act_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  cal_cfg_t cfg;
  logic adv;
  logic [PIPE_LAT-1:0] vld;
  norm_vec_t norm;
  norm_vec_t nd [LANE_LAT];
  logic [SQ_W-1:0] sq_x;
  logic [SQ_W-1:0] sq_y;
  logic [SQ_W-1:0] sq_z;
  logic [ANGLE_W-1:0] pitch;
  logic [ANGLE_W-1:0] roll;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_X: cfg.gain_x <= cfg_data;
        REG_GAIN_Y: cfg.gain_y <= cfg_data;
        REG_GAIN_Z: cfg.gain_z <= cfg_data;
        REG_OFFSET: cfg.offset <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  act_calib u_calib (
    .clk    (clk),
    .en     (adv),
    .cfg    (cfg),
    .sample (in_item),
    .norm   (norm),
    .sq_x   (sq_x),
    .sq_y   (sq_y),
    .sq_z   (sq_z)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      nd[0] <= norm;
      for (int i = 1; i < LANE_LAT; i++) begin
        nd[i] <= nd[i-1];
      end
    end
  end

  act_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk   (clk),
    .en    (adv),
    .num   (norm.x),
    .sq_a  (sq_y),
    .sq_b  (sq_z),
    .angle (pitch)
  );

  act_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk   (clk),
    .en    (adv),
    .num   (norm.y),
    .sq_a  (sq_x),
    .sq_b  (sq_z),
    .angle (roll)
  );

  act_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .last_valid (vld[PIPE_LAT-1]),
    .norm       (nd[LANE_LAT-1]),
    .pitch      (pitch),
    .roll       (roll),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .adv        (adv)
  );

  `ACT_ASSERT_IMP(a_stall_cause, clk, rst, !in_ready,
    out_valid && !out_ready && vld[PIPE_LAT-1])
  `ACT_ASSERT_NXT(a_last_delivered, clk, rst, adv && vld[PIPE_LAT-1], out_valid)
  `ACT_ASSERT_NXT(a_hold_last, clk, rst, !adv, vld[PIPE_LAT-1] && out_valid)

endmodule

/* bench/act_checker.sv */
module act_checker import act_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam longint ATAN_TBL [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  logic [REG_W-1:0] cal_row [NUM_REGS];
  out_item_t        expected_q [$];

  function automatic longint row_field(logic [REG_W-1:0] row, int j);
    logic signed [GAIN_W-1:0] f;
    f = row[j*GAIN_W +: GAIN_W];
    return longint'(f);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] tilt_angle(longint num, longint a, longint b);
    longint den, cx, cy, cz, xs, ys, r, top;
    top = longint'(180) << FRAC;
    den = longint'(floor_sqrt(longint'(a * a + b * b)));
    if (den == 0) begin
      if (num > 0) return top[ANGLE_W-1:0];
      if (num < 0) return '0;
      return ANGLE_W'(90 << FRAC);
    end
    cx = den <<< ZFRAC;
    cy = num <<< ZFRAC;
    cz = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy > 0) begin
        cx += ys; cy -= xs; cz += ATAN_TBL[i];
      end else begin
        cx -= ys; cy += xs; cz -= ATAN_TBL[i];
      end
    end
    cz += longint'(90) <<< ZFRAC;
    r = (cz + (longint'(1) <<< (ZFRAC - FRAC - 1))) >>> (ZFRAC - FRAC);
    if (r < 0) r = 0;
    if (r > top) r = top;
    return r[ANGLE_W-1:0];
  endfunction

  function automatic out_item_t calibrate_and_tilt(in_item_t s);
    longint acc [3];
    longint nv [3];
    longint sum;
    out_item_t o;
    acc[0] = longint'(s.accel_x);
    acc[1] = longint'(s.accel_y);
    acc[2] = longint'(s.accel_z);
    for (int j = 0; j < 3; j++) begin
      sum = row_field(cal_row[REG_OFFSET], j) * 8192;
      for (int i = 0; i < 3; i++) sum += acc[i] * row_field(cal_row[i], j);
      sum = (sum + 4096) >>> RND_SHIFT;
      if (sum > 524287) sum = 524287;
      if (sum < -524288) sum = -524288;
      nv[j] = sum;
    end
    o.norm_x = nv[0][NORM_W-1:0];
    o.norm_y = nv[1][NORM_W-1:0];
    o.norm_z = nv[2][NORM_W-1:0];
    o.pitch_deg = tilt_angle(nv[0], nv[1], nv[2]);
    o.roll_deg = tilt_angle(nv[1], nv[0], nv[2]);
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) cal_row[i] = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_GAIN_X: cal_row[REG_GAIN_X] = cfg_data;
          REG_GAIN_Y: cal_row[REG_GAIN_Y] = cfg_data;
          REG_GAIN_Z: cal_row[REG_GAIN_Z] = cfg_data;
          REG_OFFSET: cal_row[REG_OFFSET] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_q.push_back(calibrate_and_tilt(in_item));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item %h", out_item);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_item.norm_x !== e.norm_x) begin
            $error("norm_x exp %0d act %0d", e.norm_x, out_item.norm_x); errors++;
          end
          if (out_item.norm_y !== e.norm_y) begin
            $error("norm_y exp %0d act %0d", e.norm_y, out_item.norm_y); errors++;
          end
          if (out_item.norm_z !== e.norm_z) begin
            $error("norm_z exp %0d act %0d", e.norm_z, out_item.norm_z); errors++;
          end
          if (out_item.pitch_deg !== e.pitch_deg) begin
            $error("pitch_deg exp %0d act %0d", e.pitch_deg, out_item.pitch_deg); errors++;
          end
          if (out_item.roll_deg !== e.roll_deg) begin
            $error("roll_deg exp %0d act %0d", e.roll_deg, out_item.roll_deg); errors++;
          end
        end
      end
    end
  end
endmodule

/* bench/tb_accel_calibrate_tilt_angles_unit.sv */
module tb_accel_calibrate_tilt_angles_unit;
  import act_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int UNIT_GAIN = 536871;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  bit                   hold_req = 0;
  int                   quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  accel_calibrate_tilt_angles_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  act_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always @(negedge clk) begin
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [REG_W-1:0] pack_row(int fx, int fy, int fz);
    logic [GAIN_W-1:0] a, b, c;
    a = fx[GAIN_W-1:0];
    b = fy[GAIN_W-1:0];
    c = fz[GAIN_W-1:0];
    return {c, b, a};
  endfunction

  function automatic int rand_field();
    return int'($urandom_range(2097151)) - 1048576;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [REG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic write_all(logic [REG_W-1:0] gx, logic [REG_W-1:0] gy,
                           logic [REG_W-1:0] gz, logic [REG_W-1:0] off);
    write_reg(REG_GAIN_X, gx);
    write_reg(REG_GAIN_Y, gy);
    write_reg(REG_GAIN_Z, gz);
    write_reg(REG_OFFSET, off);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(int x, int y, int z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{accel_x: x[15:0], accel_y: y[15:0], accel_z: z[15:0]};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  task automatic random_phase(int n);
    int g;
    for (int k = 0; k < n; k++) begin
      if ((k % 150) == 0) begin
        drain();
        g = $urandom_range(3);
        if (g == 0)
          write_all(pack_row(rand_field(), rand_field(), rand_field()),
                    pack_row(rand_field(), rand_field(), rand_field()),
                    pack_row(rand_field(), rand_field(), rand_field()),
                    pack_row(rand_field(), rand_field(), rand_field()));
        else
          write_all(pack_row(UNIT_GAIN + rand_field() / 16, rand_field() / 64, rand_field() / 64),
                    pack_row(rand_field() / 64, UNIT_GAIN + rand_field() / 16, rand_field() / 64),
                    pack_row(rand_field() / 64, rand_field() / 64, UNIT_GAIN + rand_field() / 16),
                    pack_row(rand_field() / 16, rand_field() / 16, rand_field() / 16));
      end
      if ($urandom_range(3) == 0)
        send_sample(int'($urandom_range(65535)), int'($urandom_range(65535)),
                    int'($urandom_range(65535)));
      else
        send_sample(int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                    int'($urandom_range(4000)) - 2000);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers still cleared
    send_sample(1000, -1000, 500);
    send_sample(0, 0, 0);
    drain();

    write_all(pack_row(UNIT_GAIN, 0, 0), pack_row(0, UNIT_GAIN, 0),
              pack_row(0, 0, UNIT_GAIN), pack_row(0, 0, 0));
    send_sample(0, 0, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(1000, 0, 0);
    send_sample(-1000, 0, 0);
    send_sample(0, 1000, 0);
    send_sample(0, -1000, 0);
    send_sample(0, 0, 1000);
    send_sample(0, 0, -1000);
    send_sample(707, 707, 0);
    send_sample(-32768, 32767, 1);
    drain();

    // offset only, first with a zero pitch denominator
    write_all(pack_row(0, 0, 0), pack_row(0, 0, 0), pack_row(0, 0, 0),
              pack_row(65536, 0, 0));
    send_sample(123, -45, 6);
    drain();
    write_all(pack_row(0, 0, 0), pack_row(0, 0, 0), pack_row(0, 0, 0),
              pack_row(-65536, -1048576, 0));
    send_sample(0, 0, 0);
    drain();

    // saturation at extreme gains
    write_all(pack_row(1048575, -1048576, 1048575), pack_row(-1048576, 1048575, -1048576),
              pack_row(1048575, 1048575, -1048576), pack_row(1048575, -1048576, 1048575));
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(1, -1, 0);
    drain();
    write_all({REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}}, {REG_W{1'b1}});
    send_sample(32767, 32767, 32767);
    send_sample(-1, 0, 1);
    drain();

    send_idle_pct = 35;
    recv_idle_pct = 79;
    random_phase(600);
    drain();
    send_idle_pct = 79;
    recv_idle_pct = 35;
    random_phase(600);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1;
    random_phase(600);
    drain();

    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
